// ----- design/drc3_pkg.sv -----
`default_nettype none
package drc3_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int NUM_STAGES    = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
  localparam int CNT_W         = $clog2(NUM_STAGES);

  localparam int ANG_W = 16;
  localparam int SUM_W = 18;
  localparam int SPD_W = 32;
  localparam int POS_W = 48;
  localparam int XY_W  = 34;
  localparam int CS_W  = 32;
  localparam int MA_W  = 34;
  localparam int MB_W  = 32;
  localparam int P_W   = MA_W + MB_W;

  localparam int FULL_TURN    = 46080;
  localparam int HALF_TURN    = 23040;
  localparam int QUARTER_TURN = 11520;

  // Binary angle z = trunc(a * 2^32 / 46080) = trunc(a * 2^22 / 45).
  // floor(m * 2^22 / 45) is taken as (m * RECIP_45) >> 14, which can be low by one.
  localparam int Z_SHIFT     = 22;
  localparam int DIVISOR     = 45;
  localparam int RECIP_45    = 1527099483;
  localparam int RECIP_SHIFT = 14;
  localparam int MAG_W       = 14;
  localparam int Q_W         = 31;
  localparam int NUM_W       = MAG_W + Z_SHIFT;

  localparam int PROD_SHIFT = 30;
  localparam int D_W        = 34;
  localparam int CORDIC_GAIN_Q30 = 652032874;

  typedef struct packed {
    logic                   done;
    logic signed [CS_W-1:0] cos_v;
    logic signed [CS_W-1:0] sin_v;
  } cor_res_t;

  function automatic logic [ANG_W-1:0] wrap_angle(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W:0] v;
    v = (SUM_W+1)'(s);
    if (v < 0) v = v + (SUM_W+1)'(FULL_TURN);
    if (v < 0) v = v + (SUM_W+1)'(FULL_TURN);
    if (v >= (SUM_W+1)'(FULL_TURN)) v = v - (SUM_W+1)'(FULL_TURN);
    if (v >= (SUM_W+1)'(FULL_TURN)) v = v - (SUM_W+1)'(FULL_TURN);
    return v[ANG_W-1:0];
  endfunction

  function automatic logic signed [SPD_W-1:0] sat_speed(input logic signed [SPD_W+1:0] s);
    logic signed [SPD_W-1:0] r;
    if (s[SPD_W+1] == 1'b0 && s[SPD_W:SPD_W-1] != 2'b00) begin
      r = {1'b0, {(SPD_W-1){1'b1}}};
    end else if (s[SPD_W+1] == 1'b1 && s[SPD_W:SPD_W-1] != 2'b11) begin
      r = {1'b1, {(SPD_W-1){1'b0}}};
    end else begin
      r = s[SPD_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W:0] s);
    logic signed [POS_W-1:0] r;
    if (s[POS_W] != s[POS_W-1]) begin
      r = s[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end else begin
      r = s[POS_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [XY_W-1:0] atan_bam(input logic [4:0] i);
    logic signed [XY_W-1:0] r;
    case (i)
      5'd0:  r = 34'sd536870912;
      5'd1:  r = 34'sd316933406;
      5'd2:  r = 34'sd167458907;
      5'd3:  r = 34'sd85004756;
      5'd4:  r = 34'sd42667331;
      5'd5:  r = 34'sd21354465;
      5'd6:  r = 34'sd10679838;
      5'd7:  r = 34'sd5340245;
      5'd8:  r = 34'sd2670163;
      5'd9:  r = 34'sd1335087;
      5'd10: r = 34'sd667544;
      5'd11: r = 34'sd333772;
      5'd12: r = 34'sd166886;
      5'd13: r = 34'sd83443;
      5'd14: r = 34'sd41722;
      5'd15: r = 34'sd20861;
      5'd16: r = 34'sd10430;
      5'd17: r = 34'sd5215;
      5'd18: r = 34'sd2608;
      5'd19: r = 34'sd1304;
      5'd20: r = 34'sd652;
      5'd21: r = 34'sd326;
      5'd22: r = 34'sd163;
      5'd23: r = 34'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- design/dead_reckoning_3d_step_core.sv -----
`default_nettype none
// Dead-reckoning pose update. Each accepted beat adds change and noise to the
// stored elevation, heading and speed, then integrates the new velocity into
// the saturating east, north and up positions and returns the whole pose as
// one beat. The core works on one beat at a time: the time from one accepted
// input to the next is set by the CORDIC rotator that runs one stage per
// cycle for each of the two angles and by the one shared multiplier that
// forms the binary angles and the four velocity products in turn. A finished
// pose waits in the output register while the next input beat is taken.
module dead_reckoning_3d_step_core (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic signed [15:0]                     in_elevation_change,
  input  wire logic signed [15:0]                     in_heading_change,
  input  wire logic signed [15:0]                     in_speed_change,
  input  wire logic signed [15:0]                     in_elevation_noise,
  input  wire logic signed [15:0]                     in_heading_noise,
  input  wire logic signed [15:0]                     in_speed_noise,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic signed [drc3_pkg::POS_W-1:0]           out_east_out,
  output logic signed [drc3_pkg::POS_W-1:0]           out_north_out,
  output logic signed [drc3_pkg::POS_W-1:0]           out_up_out,
  output logic [drc3_pkg::ANG_W-1:0]                  out_elevation_out,
  output logic [drc3_pkg::ANG_W-1:0]                  out_heading_out,
  output logic signed [drc3_pkg::SPD_W-1:0]           out_speed_out
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_Z1   = 11'b00000000010,
    S_Z2   = 11'b00000000100,
    S_Z3   = 11'b00000001000,
    S_ROT  = 11'b00000010000,
    S_M1   = 11'b00000100000,
    S_M2   = 11'b00001000000,
    S_M3   = 11'b00010000000,
    S_M4   = 11'b00100000000,
    S_M5   = 11'b01000000000,
    S_OUT  = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [drc3_pkg::ANG_W-1:0]        elev_r, head_r;
  logic signed [drc3_pkg::SPD_W-1:0] speed_r;
  logic signed [drc3_pkg::POS_W-1:0] east_r, north_r, up_r;
  logic                              phase_r, flip_r, out_valid_r;
  logic [drc3_pkg::Q_W-1:0]          q_r;
  logic signed [drc3_pkg::CS_W-1:0]  ce_r, se_r, ch_r, sh_r;
  logic signed [drc3_pkg::D_W-1:0]   t_r;

  logic signed [drc3_pkg::MA_W-1:0]  mul_a;
  logic signed [drc3_pkg::MB_W-1:0]  mul_b;
  logic signed [drc3_pkg::P_W-1:0]   prod;
  logic signed [drc3_pkg::D_W-1:0]   prod_d;

  logic                              cor_start;
  logic signed [drc3_pkg::XY_W-1:0]  cor_z;
  drc3_pkg::cor_res_t                cor_res;

  logic signed [drc3_pkg::SUM_W-1:0] elev_sum, head_sum;
  logic signed [drc3_pkg::SPD_W+1:0] speed_sum;
  logic [drc3_pkg::ANG_W-1:0]        ang;
  logic signed [drc3_pkg::SUM_W-1:0] ang_s, red;
  logic                              flip, neg;
  logic [drc3_pkg::SUM_W-1:0]        red_abs;
  logic [drc3_pkg::MAG_W-1:0]        mag;
  logic [drc3_pkg::NUM_W-1:0]        rem;
  logic [drc3_pkg::Q_W:0]            z_mag;
  logic                              in_fire, out_free;

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign prod_d   = prod[drc3_pkg::PROD_SHIFT+drc3_pkg::D_W-1:drc3_pkg::PROD_SHIFT];

  always_comb begin
    elev_sum  = $signed({2'b00, elev_r}) + drc3_pkg::SUM_W'(in_elevation_change)
              + drc3_pkg::SUM_W'(in_elevation_noise);
    head_sum  = $signed({2'b00, head_r}) + drc3_pkg::SUM_W'(in_heading_change)
              + drc3_pkg::SUM_W'(in_heading_noise);
    speed_sum = (drc3_pkg::SPD_W+2)'(speed_r) + (drc3_pkg::SPD_W+2)'(in_speed_change)
              + (drc3_pkg::SPD_W+2)'(in_speed_noise);
  end

  // Fold the angle into [-90, 90] degrees; the middle half turn negates the results.
  always_comb begin
    ang   = phase_r ? head_r : elev_r;
    ang_s = $signed({2'b00, ang});
    flip  = 1'b0;
    if (ang > drc3_pkg::ANG_W'(3 * drc3_pkg::QUARTER_TURN)) begin
      red = ang_s - drc3_pkg::SUM_W'(drc3_pkg::FULL_TURN);
    end else if (ang > drc3_pkg::ANG_W'(drc3_pkg::QUARTER_TURN)) begin
      red  = ang_s - drc3_pkg::SUM_W'(drc3_pkg::HALF_TURN);
      flip = 1'b1;
    end else begin
      red = ang_s;
    end
    neg     = red[drc3_pkg::SUM_W-1];
    red_abs = neg ? -red : red;
    mag     = red_abs[drc3_pkg::MAG_W-1:0];
    rem     = {mag, {drc3_pkg::Z_SHIFT{1'b0}}} - prod[drc3_pkg::NUM_W-1:0];
    z_mag   = {1'b0, q_r} + (drc3_pkg::Q_W+1)'(rem >= drc3_pkg::NUM_W'(drc3_pkg::DIVISOR));
    cor_z   = neg ? -drc3_pkg::XY_W'(z_mag) : drc3_pkg::XY_W'(z_mag);
  end

  assign cor_start = (state_r == S_Z3);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_Z1: begin
        mul_a = drc3_pkg::MA_W'(mag);
        mul_b = drc3_pkg::MB_W'(drc3_pkg::RECIP_45);
      end
      S_Z2: begin
        mul_a = drc3_pkg::MA_W'(prod[drc3_pkg::RECIP_SHIFT+drc3_pkg::Q_W-1:drc3_pkg::RECIP_SHIFT]);
        mul_b = drc3_pkg::MB_W'(drc3_pkg::DIVISOR);
      end
      S_M1: begin
        mul_a = drc3_pkg::MA_W'(speed_r);
        mul_b = ce_r;
      end
      S_M2: begin
        mul_a = drc3_pkg::MA_W'(speed_r);
        mul_b = se_r;
      end
      S_M3: begin
        mul_a = t_r;
        mul_b = ch_r;
      end
      S_M4: begin
        mul_a = t_r;
        mul_b = sh_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  drc3_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  drc3_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cor_start),
    .z_in  (cor_z),
    .res   (cor_res)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_Z1;
      S_Z1:   state_nxt = S_Z2;
      S_Z2:   state_nxt = S_Z3;
      S_Z3:   state_nxt = S_ROT;
      S_ROT:  if (cor_res.done) state_nxt = phase_r ? S_M1 : S_Z1;
      S_M1:   state_nxt = S_M2;
      S_M2:   state_nxt = S_M3;
      S_M3:   state_nxt = S_M4;
      S_M4:   state_nxt = S_M5;
      S_M5:   state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      phase_r     <= 1'b0;
      elev_r      <= '0;
      head_r      <= '0;
      speed_r     <= '0;
      east_r      <= '0;
      north_r     <= '0;
      up_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (in_fire) begin
        elev_r  <= drc3_pkg::wrap_angle(elev_sum);
        head_r  <= drc3_pkg::wrap_angle(head_sum);
        speed_r <= drc3_pkg::sat_speed(speed_sum);
        phase_r <= 1'b0;
      end
      if (state_r == S_ROT && cor_res.done) phase_r <= 1'b1;
      if (state_r == S_M3) begin
        up_r <= drc3_pkg::sat_pos((drc3_pkg::POS_W+1)'(up_r) + (drc3_pkg::POS_W+1)'(prod_d));
      end
      if (state_r == S_M4) begin
        east_r <= drc3_pkg::sat_pos((drc3_pkg::POS_W+1)'(east_r) + (drc3_pkg::POS_W+1)'(prod_d));
      end
      if (state_r == S_M5) begin
        north_r <= drc3_pkg::sat_pos((drc3_pkg::POS_W+1)'(north_r)
                   + (drc3_pkg::POS_W+1)'(prod_d));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_Z2) q_r <= prod[drc3_pkg::RECIP_SHIFT+drc3_pkg::Q_W-1:drc3_pkg::RECIP_SHIFT];
    if (state_r == S_Z3) flip_r <= flip;
    if (state_r == S_ROT && cor_res.done) begin
      if (!phase_r) begin
        ce_r <= flip_r ? -cor_res.cos_v : cor_res.cos_v;
        se_r <= flip_r ? -cor_res.sin_v : cor_res.sin_v;
      end else begin
        ch_r <= flip_r ? -cor_res.cos_v : cor_res.cos_v;
        sh_r <= flip_r ? -cor_res.sin_v : cor_res.sin_v;
      end
    end
    if (state_r == S_M2) t_r <= prod_d;
    if (state_r == S_OUT && out_free) begin
      out_east_out      <= east_r;
      out_north_out     <= north_r;
      out_up_out        <= up_r;
      out_elevation_out <= elev_r;
      out_heading_out   <= head_r;
      out_speed_out     <= speed_r;
    end
  end

  assign out_valid = out_valid_r;

  a_done_in_rot: assert property (@(posedge clk) disable iff (!rst_n)
    cor_res.done |-> (state_r == S_ROT))
    else $error("rotator finished outside the rotate state");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    (elev_r < drc3_pkg::ANG_W'(drc3_pkg::FULL_TURN)) &&
    (head_r < drc3_pkg::ANG_W'(drc3_pkg::FULL_TURN)))
    else $error("stored angle left the full-turn range");

  a_recip_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_Z3) |-> (rem < drc3_pkg::NUM_W'(2 * drc3_pkg::DIVISOR)))
    else $error("reciprocal quotient off by more than one");

  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_free) |=> (out_valid_r && state_r == S_IDLE))
    else $error("pose not loaded into the output register");

endmodule
`default_nettype wire

// ----- design/drc3_mul.sv -----
`default_nettype none
module drc3_mul (
  input  wire logic                                clk,
  input  wire logic signed [drc3_pkg::MA_W-1:0]    a,
  input  wire logic signed [drc3_pkg::MB_W-1:0]    b,
  output logic signed [drc3_pkg::P_W-1:0]          p
);

  logic signed [drc3_pkg::P_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= drc3_pkg::P_W'(a) * drc3_pkg::P_W'(b);
  end

  assign p = p_r;

endmodule
`default_nettype wire

// ----- design/drc3_cordic.sv -----
`default_nettype none
module drc3_cordic (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire logic signed [drc3_pkg::XY_W-1:0]    z_in,
  output drc3_pkg::cor_res_t                       res
);

  localparam logic [drc3_pkg::CNT_W-1:0] LAST = drc3_pkg::CNT_W'(drc3_pkg::NUM_STAGES - 1);

  logic signed [drc3_pkg::XY_W-1:0] x_r, y_r, z_r;
  logic signed [drc3_pkg::XY_W-1:0] x_nxt, y_nxt, z_nxt;
  logic signed [drc3_pkg::XY_W-1:0] x_sh, y_sh, ang;
  logic [drc3_pkg::CNT_W-1:0]       cnt_r;
  logic                             busy_r;

  // One micro-rotation per cycle; the stage index sets both shifts.
  always_comb begin
    x_sh = x_r >>> cnt_r;
    y_sh = y_r >>> cnt_r;
    ang  = drc3_pkg::atan_bam(5'(cnt_r));
    if (!z_r[drc3_pkg::XY_W-1]) begin
      x_nxt = x_r - y_sh;
      y_nxt = y_r + x_sh;
      z_nxt = z_r - ang;
    end else begin
      x_nxt = x_r + y_sh;
      y_nxt = y_r - x_sh;
      z_nxt = z_r + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == LAST) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= drc3_pkg::XY_W'(drc3_pkg::CORDIC_GAIN_Q30);
      y_r <= '0;
      z_r <= z_in;
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  // The last stage's sums are handed out directly and latched by the caller.
  assign res.done  = busy_r && (cnt_r == LAST);
  assign res.cos_v = x_nxt[drc3_pkg::CS_W-1:0];
  assign res.sin_v = y_nxt[drc3_pkg::CS_W-1:0];

endmodule
`default_nettype wire
